// ===== hdl/zpf_pkg.sv =====
// Shared types and constants for the zero-phase FIR record filter.
package zpf_pkg;

    localparam int MODE_BITS = 2;
    localparam int POS_BITS  = 12;
    localparam int FO_BITS   = 8;
    localparam int RL_BITS   = 13;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [MODE_BITS-1:0] MODE_LOAD_TAP    = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_LOAD_SAMPLE = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_RUN         = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_READ        = 2'd3;

    localparam logic KIND_RUN  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic REG_FILTER_ORDER  = 1'b0;
    localparam logic REG_RECORD_LENGTH = 1'b1;

    localparam int RECORD_LENGTH_RESET = 2;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_chain_ctl;

endpackage

// ===== hdl/zero_phase_fir_record_filter_core.sv =====
// Top level of the zero-phase FIR record filter.
// Tap loads, sample loads and output reads take one beat per cycle while
// the output is not stalled; a read's result is registered by the output
// memory's read port and then by the output register. A run streams the record
// through a row of MAX_ORDER+1 transposed-FIR cells at one sample per cycle,
// forward from the sample store and then backward over the forward store.
// No item is accepted during a run.
module zero_phase_fir_record_filter_core #(
    parameter int MAX_ORDER    = 128,
    parameter int RECORD_DEPTH = 4096,
    parameter int SAMPLE_BITS  = 24,
    parameter int TAP_BITS     = 18
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [zpf_pkg::APB_AW-1:0]         paddr,
    input  logic [zpf_pkg::APB_DW-1:0]         pwdata,
    output logic [zpf_pkg::APB_DW-1:0]         prdata,
    output logic                               pready,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [zpf_pkg::MODE_BITS-1:0]      i_mode,
    input  logic [zpf_pkg::POS_BITS-1:0]       i_position,
    input  logic signed [TAP_BITS-1:0]         i_tap_value,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_result_kind,
    output logic [zpf_pkg::POS_BITS-1:0]       o_out_index,
    output logic signed [SAMPLE_BITS-1:0]      o_out_sample,
    output logic                               o_saturated
);
    import zpf_pkg::*;

    localparam int AW       = $clog2(RECORD_DEPTH);
    localparam int LW       = $clog2(RECORD_DEPTH + 1);
    localparam int OW       = $clog2(MAX_ORDER + 1);
    localparam int ACC_BITS = TAP_BITS + SAMPLE_BITS + $clog2(MAX_ORDER + 2);

    localparam logic signed [ACC_BITS:0] RND =
        (ACC_BITS+1)'(1) <<< (TAP_BITS - 2);
    localparam logic signed [ACC_BITS:0] SAT_HI =
        (ACC_BITS+1)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_BITS:0] SAT_LO = -SAT_HI - 1;
    localparam logic signed [SAMPLE_BITS-1:0] Y_MAX = SAMPLE_BITS'(SAT_HI);
    localparam logic signed [SAMPLE_BITS-1:0] Y_MIN = SAMPLE_BITS'(SAT_LO);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FWD  = 3'd1;
    localparam logic [2:0] S_FDRN = 3'd2;
    localparam logic [2:0] S_BWD  = 3'd3;
    localparam logic [2:0] S_BDRN = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [FO_BITS-1:0] r_filter_order;
    logic [RL_BITS-1:0] r_record_length;

    logic [2:0]    r_state;
    logic [LW-1:0] r_len;
    logic [OW-1:0] r_ord;
    logic [LW-1:0] r_cnt;
    logic          r_bwd;
    logic          r_sat;
    logic          r_v1;
    logic [AW-1:0] r_a1;
    logic          r_v2;
    logic [AW-1:0] r_a2;

    logic                r_rd_v;
    logic [POS_BITS-1:0] r_rd_idx;
    logic                r_rd_inr;
    logic                r_rd_sat;

    logic                          r_out_v;
    logic                          r_out_kind;
    logic [POS_BITS-1:0]           r_out_idx;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic                          r_out_sat;

    logic       w_accept;
    logic       w_mv;
    logic       w_out_free;
    logic       w_pos_inr;
    logic       w_cfg_we;
    t_chain_ctl w_ctl;

    int unsigned w_len_c;
    int unsigned w_ord_c;

    logic [AW-1:0]                 w_pos_addr;
    logic [AW-1:0]                 w_cnt_addr;
    logic [SAMPLE_BITS-1:0]        w_smp_rdata;
    logic [SAMPLE_BITS-1:0]        w_fwd_rdata;
    logic [SAMPLE_BITS-1:0]        w_out_rdata;
    logic signed [SAMPLE_BITS-1:0] w_x;
    logic signed [ACC_BITS-1:0]    w_acc;
    logic signed [ACC_BITS:0]      w_rnd;
    logic signed [ACC_BITS:0]      w_q;
    logic                          w_hi;
    logic                          w_lo;
    logic signed [SAMPLE_BITS-1:0] w_y;
    logic                          w_rd_smp;
    logic                          w_rd_fwd;
    logic                          w_tap_we;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_RECORD_LENGTH)
                    ? APB_DW'(r_record_length) : APB_DW'(r_filter_order);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_order  <= '0;
            r_record_length <= RL_BITS'(RECORD_LENGTH_RESET);
        end else if (w_cfg_we) begin
            if (paddr[2] == REG_FILTER_ORDER) begin
                r_filter_order <= pwdata[FO_BITS-1:0];
            end else begin
                r_record_length <= pwdata[RL_BITS-1:0];
            end
        end
    end

    assign w_out_free = !r_out_v || !i_out_stall;
    assign w_mv       = r_rd_v && w_out_free;
    assign o_in_stall = (r_state != S_IDLE) || (r_rd_v && !w_mv);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_pos_inr  = 32'(i_position) < RECORD_DEPTH;
    assign w_pos_addr = AW'(i_position);
    assign w_cnt_addr = r_cnt[AW-1:0];
    assign w_tap_we   = w_accept && i_mode == MODE_LOAD_TAP
                      && 32'(i_position) <= MAX_ORDER;

    always_comb begin
        w_len_c = 32'(r_record_length);
        if (w_len_c < 2) begin
            w_len_c = 2;
        end
        if (w_len_c > RECORD_DEPTH) begin
            w_len_c = RECORD_DEPTH;
        end
        w_ord_c = 32'(r_filter_order);
        if (w_ord_c > w_len_c - 1) begin
            w_ord_c = w_len_c - 1;
        end
        if (w_ord_c[0]) begin
            w_ord_c = w_ord_c + 1;
        end
        if (w_ord_c > MAX_ORDER) begin
            w_ord_c = MAX_ORDER;
        end
    end

    assign w_rd_smp = (r_state == S_FWD);
    assign w_rd_fwd = (r_state == S_BWD);

    assign w_rnd = {w_acc[ACC_BITS-1], w_acc} + RND;
    assign w_q   = w_rnd >>> (TAP_BITS - 1);
    assign w_hi  = w_q > SAT_HI;
    assign w_lo  = w_q < SAT_LO;
    assign w_y   = w_hi ? Y_MAX : (w_lo ? Y_MIN : w_q[SAMPLE_BITS-1:0]);
    assign w_x   = r_bwd ? $signed(w_fwd_rdata) : $signed(w_smp_rdata);

    always_comb begin
        w_ctl.shift = r_v1;
        w_ctl.clear = 1'b0;
        if (r_state == S_IDLE && w_accept && i_mode == MODE_RUN) begin
            w_ctl.clear = 1'b1;
        end
        if (r_state == S_FDRN && !r_v1 && !r_v2) begin
            w_ctl.clear = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sat   <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_rd_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_bwd   <= 1'b0;
        end else begin
            r_v1 <= 1'b0;
            r_v2 <= r_v1;
            r_a2 <= r_a1;
            if (r_v2 && (w_hi || w_lo)) begin
                r_sat <= 1'b1;
            end
            if (w_mv) begin
                r_rd_v <= 1'b0;
            end
            if (r_out_v && !i_out_stall) begin
                r_out_v <= 1'b0;
            end
            if (w_mv) begin
                r_out_v      <= 1'b1;
                r_out_kind   <= KIND_READ;
                r_out_idx    <= r_rd_idx;
                r_out_sample <= r_rd_inr ? $signed(w_out_rdata) : '0;
                r_out_sat    <= r_rd_sat;
            end
            if (w_accept && i_mode == MODE_READ) begin
                r_rd_v   <= 1'b1;
                r_rd_idx <= i_position;
                r_rd_inr <= w_pos_inr;
                r_rd_sat <= r_sat;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && i_mode == MODE_RUN) begin
                        r_len   <= LW'(w_len_c);
                        r_ord   <= OW'(w_ord_c);
                        r_cnt   <= '0;
                        r_sat   <= 1'b0;
                        r_bwd   <= 1'b0;
                        r_state <= S_FWD;
                    end
                end
                S_FWD: begin
                    r_v1  <= 1'b1;
                    r_a1  <= w_cnt_addr;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == r_len - 1'b1) begin
                        r_state <= S_FDRN;
                    end
                end
                S_FDRN: begin
                    if (!r_v1 && !r_v2) begin
                        r_bwd   <= 1'b1;
                        r_cnt   <= r_len - 1'b1;
                        r_state <= S_BWD;
                    end
                end
                S_BWD: begin
                    r_v1  <= 1'b1;
                    r_a1  <= w_cnt_addr;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_BDRN;
                    end
                end
                S_BDRN: begin
                    if (!r_v1 && !r_v2) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_v      <= 1'b1;
                        r_out_kind   <= KIND_RUN;
                        r_out_idx    <= '0;
                        r_out_sample <= '0;
                        r_out_sat    <= r_sat;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    zpf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(RECORD_DEPTH)) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && i_mode == MODE_LOAD_SAMPLE && w_pos_inr),
        .i_waddr (w_pos_addr),
        .i_wdata (i_sample_value),
        .i_re    (w_rd_smp),
        .i_raddr (w_cnt_addr),
        .o_rdata (w_smp_rdata)
    );

    zpf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(RECORD_DEPTH)) u_forward_ram (
        .i_clk   (i_clk),
        .i_we    (r_v2 && !r_bwd),
        .i_waddr (r_a2),
        .i_wdata (w_y),
        .i_re    (w_rd_fwd),
        .i_raddr (w_cnt_addr),
        .o_rdata (w_fwd_rdata)
    );

    zpf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(RECORD_DEPTH)) u_output_ram (
        .i_clk   (i_clk),
        .i_we    (r_v2 && r_bwd),
        .i_waddr (r_a2),
        .i_wdata (w_y),
        .i_re    (w_accept && i_mode == MODE_READ),
        .i_raddr (w_pos_addr),
        .o_rdata (w_out_rdata)
    );

    zpf_chain #(
        .MAX_ORDER   (MAX_ORDER),
        .TAP_BITS    (TAP_BITS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_BITS    (ACC_BITS),
        .IDX_BITS    (OW)
    ) u_chain (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_tap_we   (w_tap_we),
        .i_tap_idx  (OW'(i_position)),
        .i_tap_data (i_tap_value),
        .i_ord      (r_ord),
        .i_x        (w_x),
        .o_acc      (w_acc)
    );

    assign o_out_valid   = r_out_v;
    assign o_result_kind = r_out_kind;
    assign o_out_index   = r_out_idx;
    assign o_out_sample  = r_out_sample;
    assign o_saturated   = r_out_sat;

endmodule

// ===== hdl/zpf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module zpf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/zpf_cell.sv =====
// One transposed-FIR cell: holds one tap and one partial sum.
module zpf_cell #(
    parameter int K           = 0,
    parameter int TAP_BITS    = 18,
    parameter int SAMPLE_BITS = 24,
    parameter int ACC_BITS    = 50,
    parameter int IDX_BITS    = 8
) (
    input  logic                          i_clk,
    input  zpf_pkg::t_chain_ctl           i_ctl,
    input  logic                          i_tap_we,
    input  logic [IDX_BITS-1:0]           i_tap_idx,
    input  logic signed [TAP_BITS-1:0]    i_tap_data,
    input  logic [IDX_BITS-1:0]           i_ord,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic signed [ACC_BITS-1:0]    i_p,
    output logic signed [ACC_BITS-1:0]    o_p
);
    import zpf_pkg::*;

    localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(K);

    logic signed [TAP_BITS-1:0]             r_tap;
    logic signed [ACC_BITS-1:0]             r_p;
    logic signed [TAP_BITS-1:0]             w_tap;
    logic signed [TAP_BITS+SAMPLE_BITS-1:0] w_prod;

    assign w_tap  = (MY_IDX <= i_ord) ? r_tap : '0;
    assign w_prod = w_tap * i_x;

    always_ff @(posedge i_clk) begin
        if (i_tap_we && i_tap_idx == MY_IDX) begin
            r_tap <= i_tap_data;
        end
        if (i_ctl.clear) begin
            r_p <= '0;
        end else if (i_ctl.shift) begin
            r_p <= i_p + ACC_BITS'(w_prod);
        end
    end

    assign o_p = r_p;

endmodule

// ===== hdl/zpf_chain.sv =====
// Row of FIR cells; partial sums move one cell toward the output per beat.
module zpf_chain #(
    parameter int MAX_ORDER   = 128,
    parameter int TAP_BITS    = 18,
    parameter int SAMPLE_BITS = 24,
    parameter int ACC_BITS    = 50,
    parameter int IDX_BITS    = 8
) (
    input  logic                          i_clk,
    input  zpf_pkg::t_chain_ctl           i_ctl,
    input  logic                          i_tap_we,
    input  logic [IDX_BITS-1:0]           i_tap_idx,
    input  logic signed [TAP_BITS-1:0]    i_tap_data,
    input  logic [IDX_BITS-1:0]           i_ord,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    output logic signed [ACC_BITS-1:0]    o_acc
);
    import zpf_pkg::*;

    logic signed [ACC_BITS-1:0] w_p [MAX_ORDER+2];

    assign w_p[MAX_ORDER+1] = '0;

    for (genvar k = 0; k <= MAX_ORDER; k++) begin : g_cell
        zpf_cell #(
            .K           (k),
            .TAP_BITS    (TAP_BITS),
            .SAMPLE_BITS (SAMPLE_BITS),
            .ACC_BITS    (ACC_BITS),
            .IDX_BITS    (IDX_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (i_ctl),
            .i_tap_we   (i_tap_we),
            .i_tap_idx  (i_tap_idx),
            .i_tap_data (i_tap_data),
            .i_ord      (i_ord),
            .i_x        (i_x),
            .i_p        (w_p[k+1]),
            .o_p        (w_p[k])
        );
    end

    assign o_acc = w_p[0];

endmodule

// ===== bench/zero_phase_fir_record_filter_checker.sv =====
// Checker for the zero-phase FIR record filter: predicts every result and compares it.
module zero_phase_fir_record_filter_checker
    import zpf_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_AW-1:0]       paddr,
    input  logic [APB_DW-1:0]       pwdata,
    input  logic                    pready,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic [MODE_BITS-1:0]    i_mode,
    input  logic [POS_BITS-1:0]     i_position,
    input  logic signed [17:0]      i_tap_value,
    input  logic signed [23:0]      i_sample_value,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic                    i_result_kind,
    input  logic [POS_BITS-1:0]     i_out_index,
    input  logic signed [23:0]      i_out_sample,
    input  logic                    i_saturated,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_run_count,
    output int                      o_read_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAP_DEPTH = 129;
    localparam int REC_DEPTH = 4096;
    localparam longint SAMP_HI = 64'sd8388607;
    localparam longint SAMP_LO = -64'sd8388608;

    typedef struct packed {
        logic                kind;
        logic [POS_BITS-1:0] index;
        logic signed [23:0]  sample;
        logic                sat;
    } t_filter_result;

    logic [FO_BITS-1:0] order_reg;
    logic [RL_BITS-1:0] length_reg;
    longint taps [TAP_DEPTH];
    longint samples [REC_DEPTH];
    longint forward_pass [REC_DEPTH];
    longint filtered [REC_DEPTH];
    logic sat_flag;
    t_filter_result expected_results [$];

    function automatic longint round_saturate(longint acc);
        longint q;
        q = (acc + 64'sd65536) >>> 17;
        if (q > SAMP_HI) begin
            sat_flag = 1'b1;
            return SAMP_HI;
        end
        if (q < SAMP_LO) begin
            sat_flag = 1'b1;
            return SAMP_LO;
        end
        return q;
    endfunction

    task automatic run_filtfilt();
        int len;
        int ord;
        longint acc;
        len = length_reg;
        if (len < 2) len = 2;
        if (len > REC_DEPTH) len = REC_DEPTH;
        ord = order_reg;
        if (ord > len - 1) ord = len - 1;
        if (ord % 2 == 1) ord++;
        if (ord > TAP_DEPTH - 1) ord = TAP_DEPTH - 1;
        sat_flag = 1'b0;
        for (int t = 0; t < len; t++) begin
            acc = 0;
            for (int k = 0; k <= ord && k <= t; k++) acc += taps[k] * samples[t-k];
            forward_pass[t] = round_saturate(acc);
        end
        for (int t = len - 1; t >= 0; t--) begin
            acc = 0;
            for (int k = 0; k <= ord && t + k < len; k++)
                acc += taps[k] * forward_pass[t+k];
            filtered[t] = round_saturate(acc);
        end
    endtask

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_filter_result exp_r;
        if (!i_rst_n) begin
            order_reg <= '0;
            length_reg <= RL_BITS'(RECORD_LENGTH_RESET);
            sat_flag = 1'b0;
            expected_results.delete();
            o_fail_count <= 0;
            o_run_count <= 0;
            o_read_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == APB_AW'(4 * REG_FILTER_ORDER)) order_reg <= pwdata[FO_BITS-1:0];
                if (paddr == APB_AW'(4 * REG_RECORD_LENGTH)) length_reg <= pwdata[RL_BITS-1:0];
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_mode)
                    MODE_LOAD_TAP: begin
                        if (i_position < TAP_DEPTH) taps[i_position] = i_tap_value;
                    end
                    MODE_LOAD_SAMPLE: begin
                        samples[i_position] = i_sample_value;
                    end
                    MODE_RUN: begin
                        run_filtfilt();
                        exp_r = '{KIND_RUN, '0, '0, sat_flag};
                        expected_results.push_back(exp_r);
                    end
                    default: begin
                        exp_r = '{KIND_READ, i_position, 24'(filtered[i_position]), sat_flag};
                        expected_results.push_back(exp_r);
                    end
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (i_result_kind == KIND_RUN) o_run_count <= o_run_count + 1;
                    else o_read_count <= o_read_count + 1;
                    if (i_result_kind !== exp_r.kind) begin
                        $error("result_kind: expected %0d, got %0d", exp_r.kind, i_result_kind);
                        o_fail_count <= o_fail_count + 1;
                    end else if (i_out_index !== exp_r.index) begin
                        $error("out_index: expected %0d, got %0d", exp_r.index, i_out_index);
                        o_fail_count <= o_fail_count + 1;
                    end else if (i_out_sample !== exp_r.sample) begin
                        $error("out_sample: expected %0d, got %0d", exp_r.sample, i_out_sample);
                        o_fail_count <= o_fail_count + 1;
                    end else if (i_saturated !== exp_r.sat) begin
                        $error("saturated: expected %0d, got %0d", exp_r.sat, i_saturated);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== bench/zero_phase_fir_record_filter_core_tb.sv =====
// Top of the testbench: clock, reset, stimulus and verdict for the record filter core.
module zero_phase_fir_record_filter_core_tb;
    import zpf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAP_DEPTH = 129;
    localparam int REC_DEPTH = 4096;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata, prdata;
    logic in_valid, in_stall, out_valid, out_stall;
    logic [MODE_BITS-1:0] mode;
    logic [POS_BITS-1:0] position;
    logic signed [17:0] tap_value;
    logic signed [23:0] sample_value;
    logic result_kind, saturated;
    logic [POS_BITS-1:0] out_index;
    logic signed [23:0] out_sample;
    int fail_count, pending, run_count, read_count;

    bit tap_ok [TAP_DEPTH];
    bit sample_ok [REC_DEPTH];
    int filtered_hi;
    int cur_order, cur_len;
    int beats_sent, settings_used;
    bit quiet, long_hold_req, small_taps;

    zero_phase_fir_record_filter_core u_dut (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_mode(mode),
        .i_position(position), .i_tap_value(tap_value), .i_sample_value(sample_value),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_result_kind(result_kind),
        .o_out_index(out_index), .o_out_sample(out_sample), .o_saturated(saturated)
    );

    zero_phase_fir_record_filter_checker u_checker (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_mode(mode),
        .i_position(position), .i_tap_value(tap_value), .i_sample_value(sample_value),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_result_kind(result_kind),
        .i_out_index(out_index), .i_out_sample(out_sample), .i_saturated(saturated),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_run_count(run_count), .o_read_count(read_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Verification failed");
        $finish;
    end

    initial begin
        out_stall = 1'b0;
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                out_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                out_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_beat(logic [MODE_BITS-1:0] m, int pos, logic signed [17:0] tv,
                             logic signed [23:0] sv);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        position <= POS_BITS'(pos);
        tap_value <= tv;
        sample_value <= sv;
        do @(posedge i_clk); while (in_stall);
        beats_sent++;
        if (m == MODE_LOAD_TAP && pos < TAP_DEPTH) tap_ok[pos] = 1'b1;
        if (m == MODE_LOAD_SAMPLE) sample_ok[pos] = 1'b1;
        if (m == MODE_RUN && cur_len > filtered_hi) filtered_hi = cur_len;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_write(int idx, logic [APB_DW-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'(4 * idx);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(int ord_reg, int len_reg);
        drain();
        apb_write(REG_FILTER_ORDER, APB_DW'(ord_reg));
        apb_write(REG_RECORD_LENGTH, APB_DW'(len_reg));
        settings_used++;
        cur_len = len_reg;
        if (cur_len < 2) cur_len = 2;
        if (cur_len > REC_DEPTH) cur_len = REC_DEPTH;
        cur_order = ord_reg;
        if (cur_order > cur_len - 1) cur_order = cur_len - 1;
        if (cur_order % 2 == 1) cur_order++;
        if (cur_order > TAP_DEPTH - 1) cur_order = TAP_DEPTH - 1;
    endtask

    function automatic logic signed [17:0] pick_tap();
        if (small_taps) return 18'($signed($urandom_range(0, 8191)) - 4096);
        return 18'($urandom);
    endfunction

    // fill the first tap or sample that a run would use unloaded, else start a run
    task automatic run_or_fill();
        for (int k = 0; k <= cur_order; k++)
            if (!tap_ok[k]) begin
                send_beat(MODE_LOAD_TAP, k, pick_tap(), '0);
                return;
            end
        for (int t = 0; t < cur_len; t++)
            if (!sample_ok[t]) begin
                send_beat(MODE_LOAD_SAMPLE, t, '0, 24'($urandom));
                return;
            end
        send_beat(MODE_RUN, $urandom_range(0, 4095), 18'($urandom), 24'($urandom));
    endtask

    task automatic random_phase(int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                pick = $urandom_range(0, 9);
                send_beat(MODE_LOAD_TAP, pick < 8 ? $urandom_range(0, cur_order)
                          : (pick == 8 ? $urandom_range(0, 128) : $urandom_range(129, 4095)),
                          pick_tap(), 24'($urandom));
            end else if (pick < 55) begin
                send_beat(MODE_LOAD_SAMPLE, $urandom_range(0, 4) == 0 ? $urandom_range(0, 4095)
                          : $urandom_range(0, cur_len - 1), 18'($urandom), 24'($urandom));
            end else if (pick < 70 || filtered_hi == 0) begin
                run_or_fill();
            end else begin
                send_beat(MODE_READ, $urandom_range(0, filtered_hi - 1),
                          18'($urandom), 24'($urandom));
            end
        end
    endtask

    initial begin
        int ord_r, len_r;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        mode = MODE_LOAD_TAP;
        position = '0;
        tap_value = '0;
        sample_value = '0;
        quiet = 1'b0;
        long_hold_req = 1'b0;
        small_taps = 1'b0;
        filtered_hi = 0;
        beats_sent = 0;
        settings_used = 0;
        cur_order = 0;
        cur_len = 2;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extreme taps and samples, ignored tap positions, run and reads
        configure(2, 4);
        send_beat(MODE_LOAD_TAP, 0, 18'sh1FFFF, '0);
        send_beat(MODE_LOAD_TAP, 1, -18'sh20000, '0);
        send_beat(MODE_LOAD_TAP, 2, 18'sd4096, '0);
        send_beat(MODE_LOAD_TAP, 129, 18'sd77, '0);
        send_beat(MODE_LOAD_TAP, 4095, -18'sd1, '0);
        send_beat(MODE_LOAD_SAMPLE, 0, '0, 24'sh7FFFFF);
        send_beat(MODE_LOAD_SAMPLE, 1, '0, -24'sh800000);
        send_beat(MODE_LOAD_SAMPLE, 2, '0, 24'sd0);
        send_beat(MODE_LOAD_SAMPLE, 3, '0, -24'sd1);
        send_beat(MODE_RUN, 0, '0, '0);
        for (int i = 0; i < 4; i++) send_beat(MODE_READ, i, '0, '0);
        send_beat(MODE_LOAD_TAP, 0, 18'sd65536, '0);
        send_beat(MODE_LOAD_TAP, 1, 18'sd0, '0);
        send_beat(MODE_LOAD_TAP, 2, 18'sd0, '0);
        send_beat(MODE_RUN, 0, '0, '0);
        send_beat(MODE_READ, 1, '0, '0);
        send_beat(MODE_READ, 3, '0, '0);

        // clamped lengths and odd orders
        configure(255, 0);
        run_or_fill();
        send_beat(MODE_READ, 1, '0, '0);
        configure(3, 1);
        run_or_fill();

        // pause until every result is back, then a long receiver hold on a read burst
        drain();
        long_hold_req = 1'b1;
        for (int i = 0; i < 40; i++) send_beat(MODE_READ, $urandom_range(0, 1), '0, '0);

        // maximum order over a record longer than the tap row
        configure(128, 160);
        small_taps = 1'b1;
        for (int k = 0; k < TAP_DEPTH; k++) send_beat(MODE_LOAD_TAP, k, pick_tap(), '0);
        for (int t = 0; t < 160; t++) send_beat(MODE_LOAD_SAMPLE, t, '0, 24'($urandom));
        send_beat(MODE_RUN, 0, '0, '0);
        send_beat(MODE_READ, 159, '0, '0);
        configure(127, 160);
        run_or_fill();
        configure(0, 3);

        for (int p = 0; p < 14; p++) begin
            ord_r = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 12);
            len_r = $urandom_range(0, 3) == 0 ? $urandom_range(0, 300) : $urandom_range(2, 40);
            small_taps = $urandom_range(0, 1);
            quiet = (p >= 11);
            configure(ord_r, len_r);
            random_phase(28);
        end

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("Sent %0d input beats over %0d register settings.", beats_sent, settings_used);
        $display("Checked %0d run results and %0d read results.", run_count, read_count);
        if (fail_count == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule
